// ===== src/sir_frame_deframer_crc_check_assert.svh =====
// Assertion helpers for the SIR deframer.
`ifndef SIR_FRAME_DEFRAMER_CRC_CHECK_ASSERT_SVH
`define SIR_FRAME_DEFRAMER_CRC_CHECK_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define SFD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define SFD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/sfd_pkg.sv =====
`timescale 1ns / 1ps

package sfd_pkg;

  localparam int FRAME_CAPACITY = 64;
  localparam int FC_W = $clog2(FRAME_CAPACITY + 1);
  localparam int IDX_MAX = 63;

  localparam logic [7:0] SYM_BEGIN = 8'hC0;
  localparam logic [7:0] SYM_END = 8'hC1;
  localparam logic [7:0] SYM_ESC = 8'h7D;
  localparam logic [7:0] ESC_XOR = 8'h20;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_RESIDUE = 16'hF0B8;
  localparam logic [15:0] CRC_POLY = 16'h8408;

  localparam logic [3:0] HDR_LIMIT_RST = 4'd5;

  // parser phases
  localparam logic [1:0] PH_SEARCH = 2'd0;
  localparam logic [1:0] PH_HEADER = 2'd1;
  localparam logic [1:0] PH_DATA = 2'd2;
  localparam logic [1:0] PH_ESCAPE = 2'd3;

  // result kinds
  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_END = 2'd1;
  localparam logic [1:0] KIND_ABORT = 2'd2;

  typedef struct packed {
    logic [1:0] result_kind;
    logic [7:0] data_byte;
    logic [5:0] byte_index;
    logic       crc_good;
    logic       dropped_after;
  } sfd_result_t;

  typedef struct packed {
    logic [1:0]      phase;
    logic [FC_W-1:0] frame_count;
  } sfd_status_t;

  // Reflected CRC-16-CCITT, one byte.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  function automatic logic [5:0] sat_index(input logic [FC_W-1:0] v);
    if (32'(v) > IDX_MAX) begin
      return 6'(IDX_MAX);
    end
    return 6'(v);
  endfunction

endpackage

// ===== src/sfd_parser.sv =====
`timescale 1ns / 1ps

module sfd_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic [7:0]          rx_byte,
  input  logic                last_in_buffer,
  input  logic [3:0]          hdr_limit,
  output logic                res_valid,
  output sfd_pkg::sfd_result_t res,
  output sfd_pkg::sfd_status_t status
);
  import sfd_pkg::*;

  logic [1:0]      phase_r, phase_nxt;
  logic [3:0]      hc_r, hc_nxt;
  logic [15:0]     crc_r, crc_nxt;
  logic [FC_W-1:0] fc_r, fc_nxt;

  logic            do_data;
  logic            take;
  logic            data_res;
  logic [7:0]      tb;
  logic [FC_W-1:0] fc_cur;

  always_comb begin
    phase_nxt = phase_r;
    hc_nxt    = hc_r;
    crc_nxt   = crc_r;
    fc_nxt    = fc_r;
    fc_cur    = fc_r;
    do_data   = 1'b0;
    take      = 1'b0;
    data_res  = 1'b0;
    tb        = rx_byte;
    res_valid = 1'b0;
    res       = '0;

    unique case (phase_r)
      PH_SEARCH: begin
        if (rx_byte == SYM_BEGIN) begin
          hc_nxt    = 4'd1;
          crc_nxt   = CRC_INIT;
          phase_nxt = PH_HEADER;
        end
      end
      PH_HEADER: begin
        if (rx_byte == SYM_BEGIN) begin
          if ({1'b0, hc_r} + 5'd1 > {1'b0, hdr_limit}) begin
            phase_nxt = PH_SEARCH;
          end else begin
            hc_nxt = hc_r + 4'd1;
          end
        end else begin
          // first non-begin byte opens the data
          fc_cur  = '0;
          fc_nxt  = '0;
          do_data = 1'b1;
        end
      end
      PH_DATA: begin
        do_data = 1'b1;
      end
      PH_ESCAPE: begin
        phase_nxt = PH_DATA;
        take      = 1'b1;
        tb        = rx_byte ^ ESC_XOR;
      end
      default: begin
        phase_nxt = PH_SEARCH;
      end
    endcase

    if (do_data) begin
      phase_nxt = PH_DATA;
      if (rx_byte == SYM_BEGIN) begin
        res_valid       = 1'b1;
        res.result_kind = KIND_ABORT;
        res.byte_index  = sat_index(fc_cur);
        phase_nxt       = PH_SEARCH;
      end else if (rx_byte == SYM_ESC) begin
        phase_nxt = PH_ESCAPE;
      end else if (rx_byte == SYM_END) begin
        res_valid       = 1'b1;
        res.result_kind = KIND_END;
        res.byte_index  = sat_index(fc_cur);
        res.crc_good    = (crc_r == CRC_RESIDUE);
        phase_nxt       = PH_SEARCH;
      end else begin
        take = 1'b1;
      end
    end

    if (take) begin
      crc_nxt = crc_byte(crc_r, tb);
      if (32'(fc_cur) < FRAME_CAPACITY) begin
        res_valid       = 1'b1;
        res.result_kind = KIND_DATA;
        res.data_byte   = tb;
        res.byte_index  = sat_index(fc_cur);
        fc_nxt          = fc_cur + FC_W'(1);
        data_res        = 1'b1;
      end
    end

    // buffer end: drop any open frame, back to search
    if (last_in_buffer) begin
      if (phase_nxt == PH_DATA || phase_nxt == PH_ESCAPE) begin
        if (data_res) begin
          res.dropped_after = 1'b1;
        end else if (!res_valid) begin
          res_valid       = 1'b1;
          res.result_kind = KIND_ABORT;
          res.byte_index  = sat_index(fc_nxt);
        end
      end
      phase_nxt = PH_SEARCH;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SEARCH;
      hc_r    <= '0;
      crc_r   <= CRC_INIT;
      fc_r    <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      hc_r    <= hc_nxt;
      crc_r   <= crc_nxt;
      fc_r    <= fc_nxt;
    end
  end

  assign status.phase       = phase_r;
  assign status.frame_count = fc_r;

endmodule

// ===== src/sfd_out_reg.sv =====
`timescale 1ns / 1ps

module sfd_out_reg (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  sfd_pkg::sfd_result_t res,
  input  logic                 take,
  output logic                 can_accept,
  output logic                 valid,
  output sfd_pkg::sfd_result_t data
);
  import sfd_pkg::*;

  logic        valid_r;
  sfd_result_t data_r;

  // a waiting result that is taken this cycle frees the slot
  assign can_accept = !valid_r || take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (take) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= res;
    end
  end

  assign valid = valid_r;
  assign data  = data_r;

endmodule

// ===== src/sir_frame_deframer_crc_check.sv =====
`timescale 1ns / 1ps

// SIR frame deframer with CRC-16 check. Raw bytes from an IrDA SIR link come
// in one per request; in_tlast marks the last byte of a driver buffer, after
// which the parser returns to frame search. Begin bytes (0xC0) form the
// header, escapes (0x7D) flip bit 5 of the next byte, and the end byte (0xC1)
// closes the frame with a verdict on the reflected CRC-16-CCITT residue
// (init 0xFFFF, good residue 0xF0B8). Each request gives zero or one result:
// a data byte with its index, a frame end, or an abort (begin byte inside
// the data, or buffer end in mid-frame). Bytes past the frame capacity are
// not passed on but still feed the CRC. Throughput is one byte per clock:
// the parse and the byte-wide CRC update sit between the input handshake and
// a single result register, and in_tready is low only while a result waits
// and out_tready is low. Each result is registered and shows in the cycle after its byte is accepted.
// cfg_data[3:0] sets the largest number of begin bytes in a header; write it
// only while the block is idle.

module sir_frame_deframer_crc_check (
  input  logic        clk,
  input  logic        rst_n,
  // input bytes
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  logic        in_tlast,   // last_in_buffer
  // results
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] data_byte, [13:8] byte_index,
                                  // [14] crc_good, [15] dropped_after
  output logic [1:0]  out_tuser,  // [1:0] result_kind
  // header limit register
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_data    // [3:0] header_bof_limit
);
  import sfd_pkg::*;

`include "sir_frame_deframer_crc_check_assert.svh"

  logic [3:0]  hdr_limit_r;
  logic        in_acc;
  logic        res_valid;
  sfd_result_t res;
  sfd_status_t status;
  logic        out_valid;
  sfd_result_t out_res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_limit_r <= HDR_LIMIT_RST;
    end else if (cfg_valid) begin
      hdr_limit_r <= cfg_data;
    end
  end

  assign in_acc = in_tvalid && in_tready;

  sfd_parser u_parser (
    .clk            (clk),
    .rst_n          (rst_n),
    .accept         (in_acc),
    .rx_byte        (in_tdata),
    .last_in_buffer (in_tlast),
    .hdr_limit      (hdr_limit_r),
    .res_valid      (res_valid),
    .res            (res),
    .status         (status)
  );

  // result register; the parser only advances when a result slot is free
  sfd_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (in_acc && res_valid),
    .res        (res),
    .take       (out_tready),
    .can_accept (in_tready),
    .valid      (out_valid),
    .data       (out_res)
  );

  assign out_tvalid = out_valid;
  assign out_tuser  = out_res.result_kind;
  assign out_tdata  = {out_res.dropped_after, out_res.crc_good,
                       out_res.byte_index, out_res.data_byte};

  // a new request never lands on a result that is still waiting
  `SFD_ASSERT_NOW(a_no_overwrite, clk, rst_n, in_acc, !out_tvalid || out_tready, "result overwritten")
  // buffer end always returns the parser to frame search
  `SFD_ASSERT_NEXT(a_last_to_search, clk, rst_n, in_acc && in_tlast, status.phase == PH_SEARCH, "no search after buffer end")
  // only data results carry a byte or the drop mark
  `SFD_ASSERT_NOW(a_kind_fields, clk, rst_n, out_tvalid && out_tuser != KIND_DATA, out_tdata[7:0] == 8'h00 && !out_tdata[15], "stray data fields")
  // a good CRC verdict only comes with a frame end
  `SFD_ASSERT_NOW(a_crc_on_end, clk, rst_n, out_tvalid && out_tdata[14], out_tuser == KIND_END, "crc_good outside frame end")

endmodule

// ===== bench/sfd_result_checker.sv =====
`timescale 1ns / 1ps

// Watches the byte, result and limit channels of the SIR deframer, predicts
// each result from the accepted byte requests and compares field by field.
module sfd_result_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        in_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,
  input  logic [1:0]  out_tuser,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [3:0]  cfg_data,
  output int          mismatches,
  output int          results_owed
);
  import sfd_pkg::*;

  // predicted parser state
  logic [3:0]  bof_limit;
  logic [1:0]  phase;
  logic [3:0]  bof_seen;
  logic [15:0] fcs;
  int          frame_len;

  sfd_result_t expected_results[$];

  function automatic logic [15:0] fcs_next(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c;
    for (int i = 0; i < 8; i++) begin
      r = (r >> 1) ^ ((r[0] ^ b[i]) ? CRC_POLY : 16'h0000);
    end
    return r;
  endfunction

  function automatic logic [5:0] idx_of(input int n);
    return (n > IDX_MAX) ? 6'(IDX_MAX) : 6'(n);
  endfunction

  // one unescaped byte into the frame; result only below capacity
  function automatic bit fold_byte(input logic [7:0] b, output sfd_result_t res);
    res = '0;
    fcs = fcs_next(fcs, b);
    if (frame_len >= FRAME_CAPACITY) begin
      return 1'b0;
    end
    res.result_kind = KIND_DATA;
    res.data_byte = b;
    res.byte_index = idx_of(frame_len);
    frame_len++;
    return 1'b1;
  endfunction

  function automatic bit deframe_byte(input logic [7:0] b, input logic last,
                                      output sfd_result_t res);
    bit got;
    bit data_res;
    got = 1'b0;
    data_res = 1'b0;
    res = '0;
    if (phase == PH_SEARCH) begin
      if (b == SYM_BEGIN) begin
        bof_seen = 4'd1;
        fcs = CRC_INIT;
        phase = PH_HEADER;
      end
    end else if (phase == PH_HEADER && b == SYM_BEGIN) begin
      if (int'(bof_seen) + 1 > int'(bof_limit)) begin
        phase = PH_SEARCH;
      end else begin
        bof_seen = bof_seen + 4'd1;
      end
    end else if (phase == PH_ESCAPE) begin
      phase = PH_DATA;
      got = fold_byte(b ^ ESC_XOR, res);
      data_res = got;
    end else begin
      // first non-begin byte after the header opens the data
      if (phase == PH_HEADER) begin
        frame_len = 0;
        phase = PH_DATA;
      end
      if (b == SYM_BEGIN) begin
        res.result_kind = KIND_ABORT;
        res.byte_index = idx_of(frame_len);
        got = 1'b1;
        phase = PH_SEARCH;
      end else if (b == SYM_ESC) begin
        phase = PH_ESCAPE;
      end else if (b == SYM_END) begin
        res.result_kind = KIND_END;
        res.byte_index = idx_of(frame_len);
        res.crc_good = (fcs == CRC_RESIDUE);
        got = 1'b1;
        phase = PH_SEARCH;
      end else begin
        got = fold_byte(b, res);
        data_res = got;
      end
    end
    // buffer end in mid-frame drops the frame
    if (last) begin
      if (phase == PH_DATA || phase == PH_ESCAPE) begin
        if (data_res) begin
          res.dropped_after = 1'b1;
        end else if (!got) begin
          res = '0;
          res.result_kind = KIND_ABORT;
          res.byte_index = idx_of(frame_len);
          got = 1'b1;
        end
      end
      phase = PH_SEARCH;
    end
    return got;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t mismatch %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
    mismatches++;
  endtask

  task automatic check_result();
    sfd_result_t want;
    if (expected_results.size() == 0) begin
      report_mismatch("result with none outstanding", {out_tuser, out_tdata}, 0);
      return;
    end
    want = expected_results.pop_front();
    if (out_tuser != want.result_kind)
      report_mismatch("result_kind", out_tuser, want.result_kind);
    if (out_tdata[7:0] != want.data_byte)
      report_mismatch("data_byte", out_tdata[7:0], want.data_byte);
    if (out_tdata[13:8] != want.byte_index)
      report_mismatch("byte_index", out_tdata[13:8], want.byte_index);
    if (out_tdata[14] != want.crc_good)
      report_mismatch("crc_good", out_tdata[14], want.crc_good);
    if (out_tdata[15] != want.dropped_after)
      report_mismatch("dropped_after", out_tdata[15], want.dropped_after);
  endtask

  always @(posedge clk) begin
    sfd_result_t next_res;
    if (!rst_n) begin
      bof_limit = HDR_LIMIT_RST;
      phase = PH_SEARCH;
      bof_seen = 4'd0;
      fcs = CRC_INIT;
      frame_len = 0;
      mismatches = 0;
      expected_results.delete();
      results_owed <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        check_result();
      end
      if (cfg_valid && cfg_ready) begin
        bof_limit = cfg_data;
      end
      if (in_tvalid && in_tready) begin
        if (deframe_byte(in_tdata, in_tlast, next_res)) begin
          expected_results.push_back(next_res);
        end
      end
      results_owed <= expected_results.size();
    end
  end

endmodule

// ===== bench/sir_frame_deframer_crc_check_test.sv =====
`timescale 1ns / 1ps

module sir_frame_deframer_crc_check_test;
  import sfd_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RX_HOLD_CYCLES = 300;   // long receiver hold-off
  localparam int PHASE_BYTES = 190;      // random byte requests per limit setting

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [3:0]  cfg_data;

  int mismatches;
  int results_owed;
  int cycles = 0;
  int bytes_sent;
  int hdr_limit;        // limit now in the block, used to shape headers
  bit tx_steady;        // no sender gaps
  bit rx_steady;        // no receiver stalls
  int hold_requests;
  int holds_served;

  logic [7:0] wire_bytes[$];   // raw link bytes waiting to go out

  sir_frame_deframer_crc_check dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  sfd_result_checker result_watch (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tlast     (in_tlast),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tuser    (out_tuser),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .mismatches   (mismatches),
    .results_owed (results_owed)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // hard stop
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Result side: random stalls, plus one long hold-off per hold request.
  // The sender keeps offering during the hold, so the block backs up.
  initial begin
    out_tready = 1'b0;
    holds_served = 0;
    forever begin
      @(posedge clk);
      if (holds_served != hold_requests) begin
        holds_served++;
        for (int n = 0; n < RX_HOLD_CYCLES; n++) begin
          out_tready <= 1'b0;
          @(posedge clk);
        end
      end
      out_tready <= rx_steady || ($urandom_range(99) >= 16);
    end
  end

  // frame check sequence for building good frames on the link
  function automatic logic [15:0] link_fcs(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {8'h00, b};
    repeat (8) r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    return r;
  endfunction

  // payload byte, biased toward the framing symbols and the escaped form of the begin symbol
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(15))
      0: return SYM_BEGIN;
      1: return SYM_END;
      2: return SYM_ESC;
      3: return SYM_BEGIN ^ ESC_XOR;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // One byte request. Random gaps before it; the request is taken at the
  // first rising edge with in_tready high, which is looked at on the
  // falling edge where it is settled.
  task automatic send_byte(input logic [7:0] b, input bit last);
    while (!tx_steady && $urandom_range(99) < 16) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tlast <= last;
    @(negedge clk);
    while (!in_tready) @(negedge clk);
    @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_burst(input bit last_on_final);
    foreach (wire_bytes[i]) begin
      send_byte(wire_bytes[i], last_on_final && (i == wire_bytes.size() - 1));
    end
    wire_bytes.delete();
  endtask

  // header, escaped payload and check sequence, end byte
  task automatic build_frame(input int nbof, input logic [7:0] payload[$], input bit bad_fcs);
    logic [15:0] c;
    logic [7:0]  body[$];
    c = CRC_INIT;
    body = payload;
    foreach (payload[i]) c = link_fcs(c, payload[i]);
    c = ~c;
    if (bad_fcs) c = c ^ (16'h0001 << $urandom_range(15));
    body.push_back(c[7:0]);
    body.push_back(c[15:8]);
    repeat (nbof) wire_bytes.push_back(SYM_BEGIN);
    foreach (body[i]) begin
      if (body[i] == SYM_BEGIN || body[i] == SYM_END || body[i] == SYM_ESC) begin
        wire_bytes.push_back(SYM_ESC);
        wire_bytes.push_back(body[i] ^ ESC_XOR);
      end else begin
        wire_bytes.push_back(body[i]);
      end
    end
    wire_bytes.push_back(SYM_END);
  endtask

  // Stop requests, wait for every outstanding result, then idle before going on.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (results_owed != 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(input int v);
    cfg_valid <= 1'b1;
    cfg_data <= 4'(v);
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
    cfg_valid <= 1'b0;
    hdr_limit = v;
  endtask

  // Mostly well-formed frames with random content; the rest are long
  // headers, aborts, escape corner cases, buffer ends and line noise.
  task automatic run_traffic(input int n);
    int stop_at;
    int r;
    int len;
    int nb;
    logic [7:0] payload[$];
    stop_at = bytes_sent + n;
    // one frame at or past capacity in every setting
    repeat ($urandom_range(62, 70)) payload.push_back(pick_byte());
    build_frame(1, payload, 1'b0);
    send_burst(1'b1);
    while (bytes_sent < stop_at) begin
      r = $urandom_range(99);
      payload.delete();
      len = ($urandom_range(99) < 3) ? $urandom_range(60, 70) : $urandom_range(0, 12);
      repeat (len) payload.push_back(pick_byte());
      nb = $urandom_range(1, (hdr_limit > 1) ? hdr_limit : 1);
      if (r < 60) begin
        build_frame(nb, payload, $urandom_range(99) < 15);
        if ($urandom_range(99) < 8) begin
          // buffer ends somewhere inside the frame
          repeat ($urandom_range(1, wire_bytes.size() - 2)) void'(wire_bytes.pop_back());
          send_burst(1'b1);
        end else begin
          send_burst($urandom_range(1));
        end
      end else if (r < 70) begin
        // header longer than the limit
        build_frame(hdr_limit + 1 + $urandom_range(2), payload, 1'b0);
        send_burst($urandom_range(1));
      end else if (r < 78) begin
        // begin byte lands in the data
        build_frame(nb, payload, 1'b0);
        repeat ($urandom_range(1, 3)) void'(wire_bytes.pop_back());
        wire_bytes.push_back(SYM_BEGIN);
        send_burst(1'b0);
      end else if (r < 86) begin
        // escape followed by anything, raw payload, maybe escape at buffer end
        wire_bytes = '{SYM_BEGIN, SYM_ESC, pick_byte()};
        foreach (payload[i]) wire_bytes.push_back(payload[i]);
        if ($urandom_range(1)) begin
          wire_bytes.push_back(SYM_ESC);
          send_burst(1'b1);
        end else begin
          wire_bytes.push_back(SYM_END);
          send_burst($urandom_range(1));
        end
      end else begin
        repeat ($urandom_range(1, 8)) send_byte(pick_byte(), $urandom_range(99) < 20);
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = 8'h00;
    in_tlast = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = 4'd0;
    bytes_sent = 0;
    hdr_limit = int'(HDR_LIMIT_RST);
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    hold_requests = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed, reset limit
    // clean frame: extreme bytes and an escaped end symbol in the payload
    build_frame(1, '{8'h00, 8'hFF, SYM_END}, 1'b0);
    send_burst(1'b1);
    // begin byte after escape is data, then end with a bad check sequence
    wire_bytes = '{SYM_BEGIN, SYM_ESC, SYM_BEGIN, SYM_END};
    send_burst(1'b0);
    // header one past the limit goes back to search
    repeat (hdr_limit + 1) wire_bytes.push_back(SYM_BEGIN);
    send_burst(1'b0);
    // begin byte inside the data aborts
    wire_bytes = '{SYM_BEGIN, 8'h11, SYM_BEGIN};
    send_burst(1'b0);
    // buffer ends: on a data byte, on an escape, inside a header
    wire_bytes = '{SYM_BEGIN, 8'h22};
    send_burst(1'b1);
    wire_bytes = '{SYM_BEGIN, SYM_ESC};
    send_burst(1'b1);
    wire_bytes = '{SYM_BEGIN, SYM_BEGIN};
    send_burst(1'b1);

    // random traffic over several limit settings
    run_traffic(PHASE_BYTES);
    drain();
    write_limit(15);
    run_traffic(PHASE_BYTES);
    drain();
    write_limit(0);
    hold_requests++;   // long result stall while requests keep coming
    run_traffic(PHASE_BYTES);
    drain();
    write_limit(1);
    tx_steady = 1'b1;
    rx_steady = 1'b1;
    run_traffic(PHASE_BYTES);
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    drain();
    write_limit($urandom_range(2, 14));
    run_traffic(PHASE_BYTES);

    drain();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/sfd_pkg.sv
src/sfd_parser.sv
src/sfd_out_reg.sv
src/sir_frame_deframer_crc_check.sv
bench/sfd_result_checker.sv
bench/sir_frame_deframer_crc_check_test.sv
